### design/srg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types, constants and the arx round function for the sparse entry generator
// no dependencies
package srg_pkg;

  localparam int unsigned ROUND_COUNT_DEF = 32;
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned ROT_RIGHT = 8;
  localparam int unsigned ROT_LEFT = 3;
  localparam int unsigned MULT_SHIFT = 61;
  localparam int unsigned DIV_STAGES = 64;

  localparam logic [63:0] X_INIT = 64'h0000_0000_BAAD_CAFE;
  localparam logic [63:0] B_INIT = 64'h0000_0000_DEAD_BEEF;

  localparam logic [63:0] SEED_RST = 64'd1;
  localparam logic [30:0] ROWS_RST = 31'd1;
  localparam logic [30:0] COLS_RST = 31'd1;
  localparam logic [15:0] EPR_RST = 16'd1;
  localparam logic [30:0] PRIME_RST = 31'd2;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_SEED = 3'd0;
  localparam reg_idx_t REG_ROWS = 3'd1;
  localparam reg_idx_t REG_COLS = 3'd2;
  localparam reg_idx_t REG_EPR = 3'd3;
  localparam reg_idx_t REG_PRIME = 3'd4;

  typedef struct packed {
    logic [63:0] p;
    logic [63:0] q;
  } pair_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] a;
    logic [63:0] b;
  } prf_st_t;

  function automatic pair_t arx_round(input logic [63:0] p, input logic [63:0] q,
                                      input logic [63:0] k);
    pair_t res;
    res.p = (({p[ROT_RIGHT-1:0], p[63:ROT_RIGHT]}) + q) ^ k;
    res.q = {q[63-ROT_LEFT:0], q[63:64-ROT_LEFT]} ^ res.p;
    return res;
  endfunction

  // v * (2^61 - 1) + c, modulo 2^64
  function automatic logic [63:0] key_mix(input logic [63:0] v, input logic [63:0] c);
    return (v << MULT_SHIFT) - v + c;
  endfunction

endpackage
`default_nettype wire

### design/sparse_random_entry_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// sparse random entry generator: config registers, key pipeline, arx rounds, remainder pipeline
// depends on srg_pkg
//
// channel   direction  handshake                 payload
// config    in/out     psel penable pwrite       paddr pwdata prdata
// request   in         start (busy stays low)    in_row_index in_entry_index
// result    out        out_valid, one cycle      out_column_index out_entry_value
//
// one transaction enters per cycle
// the pipe is made of 4 key stages, ROUND_COUNT+1 round stages, 1 finish stage,
// 64 remainder stages and the output register
// synchronous active-low reset clears valid bits and the config registers
// the receiver cannot stall, so no back-pressure exists inside the pipe
module sparse_random_entry_generator_top #(
  parameter int unsigned ROUND_COUNT = srg_pkg::ROUND_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srg_pkg::ADDR_W-1:0]  paddr,
  input  logic [srg_pkg::DATA_W-1:0]  pwdata,
  output logic [srg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [30:0]                 in_row_index,
  input  logic [15:0]                 in_entry_index,
  output logic                        out_valid,
  output logic [30:0]                 out_column_index,
  output logic [30:0]                 out_entry_value
);
  import srg_pkg::*;

  localparam int unsigned NS = ROUND_COUNT + 1;

  logic [63:0] seed_r;
  logic [30:0] rows_r;
  logic [30:0] cols_r;
  logic [15:0] epr_r;
  logic [30:0] prime_r;
  reg_idx_t    widx;
  logic        wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign widx   = paddr[ADDR_W-1:3];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= SEED_RST;
      rows_r  <= ROWS_RST;
      cols_r  <= COLS_RST;
      epr_r   <= EPR_RST;
      prime_r <= PRIME_RST;
    end else if (wr_en) begin
      unique case (widx)
        REG_SEED:  seed_r  <= pwdata;
        REG_ROWS:  rows_r  <= pwdata[30:0];
        REG_COLS:  cols_r  <= pwdata[30:0];
        REG_EPR:   epr_r   <= pwdata[15:0];
        REG_PRIME: prime_r <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_SEED:  prdata = seed_r;
      REG_ROWS:  prdata = {33'd0, rows_r};
      REG_COLS:  prdata = {33'd0, cols_r};
      REG_EPR:   prdata = {48'd0, epr_r};
      REG_PRIME: prdata = {33'd0, prime_r};
      default:   prdata = '0;
    endcase
  end

  // value key stages
  logic        vk_v_r   [4];
  logic [30:0] vk_row_r [4];
  logic [15:0] vk_k_r   [4];
  logic [63:0] vk_key_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) vk_v_r[i] <= 1'b0;
    end else begin
      vk_v_r[0] <= start & ~busy;
      for (int i = 1; i < 4; i++) vk_v_r[i] <= vk_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    vk_row_r[0] <= in_row_index;
    vk_k_r[0]   <= in_entry_index;
    vk_key_r[0] <= key_mix(seed_r, {33'd0, rows_r});
    vk_key_r[1] <= key_mix(vk_key_r[0], {33'd0, cols_r});
    vk_key_r[2] <= key_mix(vk_key_r[1], {48'd0, epr_r});
    vk_key_r[3] <= key_mix(vk_key_r[2], {33'd0, prime_r});
    for (int i = 1; i < 4; i++) begin
      vk_row_r[i] <= vk_row_r[i-1];
      vk_k_r[i]   <= vk_k_r[i-1];
    end
  end

  // round stages, lane 0 gives the column, lane 1 the value
  logic        prf_v_r [NS];
  logic [15:0] prf_k_r [NS];
  prf_st_t     prf_r   [NS][2];
  prf_st_t     prf_init [2];
  logic [63:0] nonce   [2];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      nonce[p]      = {47'd0, vk_k_r[3], p[0]};
      prf_init[p].x = X_INIT;
      prf_init[p].y = nonce[p] + {1'b0, vk_row_r[3], 32'd0};
      prf_init[p].b = B_INIT;
    end
    prf_init[0].a = seed_r;
    prf_init[1].a = vk_key_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) prf_v_r[s] <= 1'b0;
    end else begin
      prf_v_r[0] <= vk_v_r[3];
      for (int s = 1; s < NS; s++) prf_v_r[s] <= prf_v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    prf_k_r[0] <= vk_k_r[3];
    for (int s = 1; s < NS; s++) prf_k_r[s] <= prf_k_r[s-1];
  end

  for (genvar s = 0; s < NS; s++) begin : g_round
    for (genvar p = 0; p < 2; p++) begin : g_lane
      prf_st_t cur;
      prf_st_t prf_nxt;
      pair_t   xy;
      pair_t   ab;
      if (s == 0) begin : g_first
        assign cur = prf_init[p];
      end else begin : g_next
        assign cur = prf_r[s-1][p];
      end
      if (s < ROUND_COUNT) begin : g_key
        assign ab = arx_round(cur.a, cur.b, 64'(s));
      end else begin : g_last
        assign ab.p = cur.a;
        assign ab.q = cur.b;
      end
      always_comb begin
        xy        = arx_round(cur.x, cur.y, cur.b);
        prf_nxt.x = xy.p;
        prf_nxt.y = xy.q;
        prf_nxt.a = ab.p;
        prf_nxt.b = ab.q;
      end
      always_ff @(posedge clk) begin
        prf_r[s][p] <= prf_nxt;
      end
    end
  end

  // finish stage: output word of the function
  logic        fin_v_r;
  logic [63:0] fin_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) fin_v_r <= 1'b0;
    else fin_v_r <= prf_v_r[NS-1];
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < 2; p++) begin
      fin_r[p] <= prf_r[NS-1][p].x + {47'd0, prf_k_r[NS-1], p[0]};
    end
  end

  // restoring remainder, one quotient bit per stage
  logic        div_v_r   [DIV_STAGES];
  logic [30:0] div_rem_r [DIV_STAGES][2];
  logic [63:0] div_q_r   [DIV_STAGES][2];
  logic [30:0] divisor   [2];

  assign divisor[0] = cols_r;
  assign divisor[1] = prime_r - 31'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_STAGES; j++) div_v_r[j] <= 1'b0;
    end else begin
      div_v_r[0] <= fin_v_r;
      for (int j = 1; j < DIV_STAGES; j++) div_v_r[j] <= div_v_r[j-1];
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    for (genvar p = 0; p < 2; p++) begin : g_lane
      logic [30:0] rem_in;
      logic [63:0] q_in;
      logic [31:0] trial;
      logic [31:0] diff;
      if (j == 0) begin : g_first
        assign rem_in = '0;
        assign q_in   = fin_r[p];
      end else begin : g_next
        assign rem_in = div_rem_r[j-1][p];
        assign q_in   = div_q_r[j-1][p];
      end
      assign trial = {rem_in, q_in[63]};
      assign diff  = trial - {1'b0, divisor[p]};
      always_ff @(posedge clk) begin
        div_rem_r[j][p] <= (trial >= {1'b0, divisor[p]}) ? diff[30:0] : trial[30:0];
        div_q_r[j][p]   <= {q_in[62:0], 1'b0};
      end
    end
  end

  // output register
  logic        out_valid_r;
  logic [30:0] col_r;
  logic [30:0] val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= div_v_r[DIV_STAGES-1];
  end

  always_ff @(posedge clk) begin
    col_r <= (cols_r == 31'd0) ? 31'd0 : div_rem_r[DIV_STAGES-1][0];
    val_r <= (prime_r < 31'd2) ? 31'd1 : div_rem_r[DIV_STAGES-1][1] + 31'd1;
  end

  assign out_valid        = out_valid_r;
  assign out_column_index = col_r;
  assign out_entry_value  = val_r;

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cols_r != 31'd0 |-> out_column_index < cols_r)
    else $error("column out of range");

  a_val_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && prime_r >= 31'd2 |-> out_entry_value < prime_r)
    else $error("value out of range");

  a_val_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_value != 31'd0)
    else $error("zero value");

  a_pipe_move: assert property (@(posedge clk) disable iff (!rst_n)
    fin_v_r |=> div_v_r[0])
    else $error("transaction lost entering remainder stages");

endmodule
`default_nettype wire
